>>> rtl/rcsc_pkg.sv
// Shared types and constants for the region color scene classifier.
`timescale 1ns / 1ps

package rcsc_pkg;

  // Field widths
  localparam int COORD_W  = 10;
  localparam int CHAN_W   = 8;
  localparam int SPAN_W   = 10;
  localparam int NOISE_W  = 8;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 10;

  // Pixels at or beyond this column or row fall in no box
  localparam int MAX_DIM = 1024;

  // Accumulator layout: box-major, channels blue, green, red
  localparam int NUM_BOXES = 3;
  localparam int NUM_CHAN  = 3;
  localparam int NUM_SUMS  = NUM_BOXES * NUM_CHAN;
  localparam int SUM_W     = 28;
  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

  // Box area is at most 1024 * 1024
  localparam int AREA_W = 2 * SPAN_W + 1;

  // Frames of sums waiting for the back end
  localparam int QUEUE_DEPTH = 2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LEFT_BOX_X   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT_BOX_X  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_BOX_X = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_UPPER_BOX_Y  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_BOX_Y = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_SPAN_X   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_SPAN_Y   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_NOISE_LEVEL  = 3'd7;

  // Register reset values
  localparam logic [COORD_W-1:0] RST_LEFT_BOX_X   = 10'd32;
  localparam logic [COORD_W-1:0] RST_RIGHT_BOX_X  = 10'd224;
  localparam logic [COORD_W-1:0] RST_CENTER_BOX_X = 10'd128;
  localparam logic [COORD_W-1:0] RST_UPPER_BOX_Y  = 10'd24;
  localparam logic [COORD_W-1:0] RST_CENTER_BOX_Y = 10'd96;
  localparam logic [SPAN_W-1:0]  RST_BOX_SPAN_X   = 10'd64;
  localparam logic [SPAN_W-1:0]  RST_BOX_SPAN_Y   = 10'd48;
  localparam logic [NOISE_W-1:0] RST_NOISE_LEVEL  = 8'd50;

  // Box color codes
  localparam logic [1:0] COLOR_OTHER = 2'd0;
  localparam logic [1:0] COLOR_RED   = 2'd1;
  localparam logic [1:0] COLOR_BLUE  = 2'd2;

  // Scene codes
  localparam logic [2:0] SCENE_NONE      = 3'd0;
  localparam logic [2:0] SCENE_RED_BASE  = 3'd1;
  localparam logic [2:0] SCENE_BLUE_BASE = 3'd2;
  localparam logic [2:0] SCENE_RED_PUCK  = 3'd3;
  localparam logic [2:0] SCENE_BLUE_PUCK = 3'd4;

  typedef logic [SUM_W-1:0] sum_t;
  typedef sum_t [NUM_SUMS-1:0] sum_bank_t;

  typedef struct packed {
    logic [COORD_W-1:0] left_box_x;
    logic [COORD_W-1:0] right_box_x;
    logic [COORD_W-1:0] center_box_x;
    logic [COORD_W-1:0] upper_box_y;
    logic [COORD_W-1:0] center_box_y;
    logic [SPAN_W-1:0]  box_span_x;
    logic [SPAN_W-1:0]  box_span_y;
    logic [NOISE_W-1:0] noise_level;
  } cfg_t;

  typedef struct packed {
    logic [COORD_W-1:0] pixel_x;
    logic [COORD_W-1:0] pixel_y;
    logic [CHAN_W-1:0]  blue;
    logic [CHAN_W-1:0]  green;
    logic [CHAN_W-1:0]  red;
    logic               frame_last;
  } pixel_t;

  typedef struct packed {
    logic [2:0] scene;
    logic       scene_changed;
    logic [1:0] left_color;
    logic [1:0] right_color;
    logic [1:0] center_color;
  } result_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_AREA,
    BK_DIV,
    BK_CLASS,
    BK_EMIT
  } back_state_t;

endpackage

>>> rtl/rcsc_front.sv
// Front end: takes pixels and accumulates per-box channel sums.
`timescale 1ns / 1ps

module rcsc_front (
  input  logic                clk,
  input  logic                rst,
  input  rcsc_pkg::cfg_t      cfg,
  input  logic                in_valid,
  output logic                in_stall,
  input  rcsc_pkg::pixel_t    in_data,
  input  logic                q_full,
  output logic                push,
  output rcsc_pkg::sum_bank_t push_data
);

  rcsc_pkg::sum_bank_t sums;
  rcsc_pkg::sum_bank_t sums_next;

  logic [rcsc_pkg::COORD_W-1:0] org_x [rcsc_pkg::NUM_BOXES];
  logic [rcsc_pkg::COORD_W-1:0] org_y [rcsc_pkg::NUM_BOXES];
  logic                         hit   [rcsc_pkg::NUM_BOXES];
  logic [rcsc_pkg::CHAN_W-1:0]  chan  [rcsc_pkg::NUM_CHAN];
  logic [rcsc_pkg::SUM_W:0]     wide  [rcsc_pkg::NUM_SUMS];
  logic                         on_grid;
  logic                         accept;

  assign accept   = in_valid & ~in_stall;
  assign in_stall = q_full;
  assign push     = accept & in_data.frame_last;

  // Box origins: left and right share the upper row
  assign org_x[0] = cfg.left_box_x;
  assign org_y[0] = cfg.upper_box_y;
  assign org_x[1] = cfg.right_box_x;
  assign org_y[1] = cfg.upper_box_y;
  assign org_x[2] = cfg.center_box_x;
  assign org_y[2] = cfg.center_box_y;

  assign chan[0] = in_data.blue;
  assign chan[1] = in_data.green;
  assign chan[2] = in_data.red;

  assign on_grid =
    ({3'b000, in_data.pixel_x} < 13'(rcsc_pkg::MAX_DIM)) &&
    ({3'b000, in_data.pixel_y} < 13'(rcsc_pkg::MAX_DIM));

  // Inclusive box test, end computed without wrap
  always_comb begin
    for (int b = 0; b < rcsc_pkg::NUM_BOXES; b++) begin
      hit[b] = on_grid &&
        (in_data.pixel_x >= org_x[b]) &&
        ({1'b0, in_data.pixel_x} <= ({1'b0, org_x[b]} + {1'b0, cfg.box_span_x})) &&
        (in_data.pixel_y >= org_y[b]) &&
        ({1'b0, in_data.pixel_y} <= ({1'b0, org_y[b]} + {1'b0, cfg.box_span_y}));
    end
  end

  // Saturating accumulate
  always_comb begin
    for (int b = 0; b < rcsc_pkg::NUM_BOXES; b++) begin
      for (int c = 0; c < rcsc_pkg::NUM_CHAN; c++) begin
        wide[b * rcsc_pkg::NUM_CHAN + c] =
          {1'b0, sums[b * rcsc_pkg::NUM_CHAN + c]} + (rcsc_pkg::SUM_W + 1)'(chan[c]);
        if (!hit[b]) begin
          sums_next[b * rcsc_pkg::NUM_CHAN + c] = sums[b * rcsc_pkg::NUM_CHAN + c];
        end else if (wide[b * rcsc_pkg::NUM_CHAN + c][rcsc_pkg::SUM_W]) begin
          sums_next[b * rcsc_pkg::NUM_CHAN + c] = rcsc_pkg::SUM_MAX;
        end else begin
          sums_next[b * rcsc_pkg::NUM_CHAN + c] =
            wide[b * rcsc_pkg::NUM_CHAN + c][rcsc_pkg::SUM_W-1:0];
        end
      end
    end
  end

  // Last pixel of a frame hands the totals to the queue
  assign push_data = sums_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      sums <= '0;
    end else if (accept) begin
      if (in_data.frame_last) begin
        sums <= '0;
      end else begin
        sums <= sums_next;
      end
    end
  end

endmodule

>>> rtl/rcsc_queue.sv
// Short queue of frame totals between the front and back ends.
`timescale 1ns / 1ps

module rcsc_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  rcsc_pkg::sum_bank_t push_data,
  output logic                full,
  input  logic                pop,
  output logic                empty,
  output rcsc_pkg::sum_bank_t head
);

  localparam int PTR_W = (rcsc_pkg::QUEUE_DEPTH > 1) ? $clog2(rcsc_pkg::QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(rcsc_pkg::QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(rcsc_pkg::QUEUE_DEPTH - 1);

  rcsc_pkg::sum_bank_t entry [rcsc_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full  = (count == CNT_W'(rcsc_pkg::QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = entry[rd_ptr];

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> rtl/rcsc_back.sv
// Back end: divides frame totals by box area, classes boxes, forms the scene.
`timescale 1ns / 1ps

module rcsc_back (
  input  logic                clk,
  input  logic                rst,
  input  rcsc_pkg::cfg_t      cfg,
  input  logic                q_empty,
  input  rcsc_pkg::sum_bank_t q_head,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output rcsc_pkg::result_t   out_data
);

  localparam int SUM_W  = rcsc_pkg::SUM_W;
  localparam int AREA_W = rcsc_pkg::AREA_W;
  localparam int BIT_W  = $clog2(SUM_W);
  localparam int IDX_W  = $clog2(rcsc_pkg::NUM_SUMS);
  localparam int BOX_W  = $clog2(rcsc_pkg::NUM_BOXES);

  rcsc_pkg::back_state_t state, state_next;
  logic                  load_out;

  rcsc_pkg::sum_t    chain [rcsc_pkg::NUM_SUMS];
  logic [SUM_W-1:0]  dvd;
  logic [AREA_W-1:0] rem;
  logic [AREA_W-1:0] area;
  logic [BIT_W-1:0]  bit_cnt;
  logic [IDX_W-1:0]  div_idx;
  logic [BOX_W-1:0]  box_cnt;
  logic [1:0]        box_color [rcsc_pkg::NUM_BOXES];
  logic [2:0]        cur_scene;
  logic [2:0]        scene_new;

  logic [AREA_W:0]   shifted;
  logic [AREA_W:0]   trial;
  logic              q_bit;
  logic [AREA_W-1:0] rem_step;
  logic [SUM_W-1:0]  quot;
  logic              div_last;
  logic              idx_last;
  logic              box_last;
  logic [1:0]        color_now;

  function automatic logic [SUM_W-1:0] abs_diff(input logic [SUM_W-1:0] a,
                                                 input logic [SUM_W-1:0] b);
    return (a > b) ? a - b : b - a;
  endfunction

  // Grey test first, then dominant channel over the noise floor
  function automatic logic [1:0] classify(input logic [SUM_W-1:0] bl,
                                          input logic [SUM_W-1:0] gr,
                                          input logic [SUM_W-1:0] rd,
                                          input logic [rcsc_pkg::NOISE_W-1:0] noise);
    logic [SUM_W-1:0] n;
    logic [1:0]       res;
    n = SUM_W'(noise);
    if (abs_diff(bl, gr) < n && abs_diff(gr, rd) < n && abs_diff(rd, bl) < n) begin
      res = rcsc_pkg::COLOR_OTHER;
    end else if (bl > gr && bl > rd) begin
      res = (bl > n) ? rcsc_pkg::COLOR_BLUE : rcsc_pkg::COLOR_OTHER;
    end else if (rd > gr) begin
      res = (rd > n) ? rcsc_pkg::COLOR_RED : rcsc_pkg::COLOR_OTHER;
    end else begin
      res = rcsc_pkg::COLOR_OTHER;
    end
    return res;
  endfunction

  // Restoring divider step, one quotient bit per cycle
  assign shifted  = {rem, dvd[SUM_W-1]};
  assign trial    = shifted - {1'b0, area};
  assign q_bit    = (shifted >= {1'b0, area});
  assign rem_step = q_bit ? trial[AREA_W-1:0] : shifted[AREA_W-1:0];
  assign quot     = {dvd[SUM_W-2:0], q_bit};

  assign div_last = (bit_cnt == BIT_W'(SUM_W - 1));
  assign idx_last = (div_idx == IDX_W'(rcsc_pkg::NUM_SUMS - 1));
  assign box_last = (box_cnt == BOX_W'(rcsc_pkg::NUM_BOXES - 1));

  // Head of the chain holds blue, green, red of the box being classed
  assign color_now = classify(chain[0], chain[1], chain[2], cfg.noise_level);

  // Scene from the three box classes
  always_comb begin
    if (box_color[2] == rcsc_pkg::COLOR_OTHER) begin
      scene_new = rcsc_pkg::SCENE_NONE;
    end else if (box_color[2] == box_color[0] && box_color[2] == box_color[1]) begin
      scene_new = (box_color[2] == rcsc_pkg::COLOR_RED) ?
                  rcsc_pkg::SCENE_RED_BASE : rcsc_pkg::SCENE_BLUE_BASE;
    end else begin
      scene_new = (box_color[2] == rcsc_pkg::COLOR_RED) ?
                  rcsc_pkg::SCENE_RED_PUCK : rcsc_pkg::SCENE_BLUE_PUCK;
    end
  end

  // Sequencer: next state and strobes
  always_comb begin
    state_next = state;
    pop        = 1'b0;
    load_out   = 1'b0;
    case (state)
      rcsc_pkg::BK_IDLE: begin
        if (!q_empty) begin
          pop        = 1'b1;
          state_next = rcsc_pkg::BK_AREA;
        end
      end
      rcsc_pkg::BK_AREA: begin
        state_next = rcsc_pkg::BK_DIV;
      end
      rcsc_pkg::BK_DIV: begin
        if (div_last && idx_last) begin
          state_next = rcsc_pkg::BK_CLASS;
        end
      end
      rcsc_pkg::BK_CLASS: begin
        if (box_last) begin
          state_next = rcsc_pkg::BK_EMIT;
        end
      end
      rcsc_pkg::BK_EMIT: begin
        if (!out_valid || !out_stall) begin
          load_out   = 1'b1;
          state_next = rcsc_pkg::BK_IDLE;
        end
      end
      default: begin
        state_next = rcsc_pkg::BK_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= rcsc_pkg::BK_IDLE;
      out_valid <= 1'b0;
      cur_scene <= rcsc_pkg::SCENE_NONE;
    end else begin
      state <= state_next;
      if (load_out) begin
        out_valid <= 1'b1;
        cur_scene <= scene_new;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    case (state)
      rcsc_pkg::BK_IDLE: begin
        if (pop) begin
          for (int i = 0; i < rcsc_pkg::NUM_SUMS; i++) begin
            chain[i] <= q_head[i];
          end
        end
      end
      rcsc_pkg::BK_AREA: begin
        area    <= (AREA_W'(cfg.box_span_x) + 1'b1) * (AREA_W'(cfg.box_span_y) + 1'b1);
        dvd     <= chain[0];
        rem     <= '0;
        bit_cnt <= '0;
        div_idx <= '0;
        box_cnt <= '0;
      end
      rcsc_pkg::BK_DIV: begin
        if (div_last) begin
          // Quotient enters the tail, next total moves to the head
          for (int i = 0; i < rcsc_pkg::NUM_SUMS - 1; i++) begin
            chain[i] <= chain[i + 1];
          end
          chain[rcsc_pkg::NUM_SUMS - 1] <= quot;
          dvd     <= chain[1];
          rem     <= '0;
          bit_cnt <= '0;
          div_idx <= div_idx + 1'b1;
        end else begin
          dvd     <= quot;
          rem     <= rem_step;
          bit_cnt <= bit_cnt + 1'b1;
        end
      end
      rcsc_pkg::BK_CLASS: begin
        box_color[box_cnt] <= color_now;
        for (int i = 0; i < rcsc_pkg::NUM_SUMS - rcsc_pkg::NUM_CHAN; i++) begin
          chain[i] <= chain[i + rcsc_pkg::NUM_CHAN];
        end
        box_cnt <= box_cnt + 1'b1;
      end
      rcsc_pkg::BK_EMIT: begin
        if (load_out) begin
          out_data.scene         <= scene_new;
          out_data.scene_changed <= (scene_new != cur_scene);
          out_data.left_color    <= box_color[0];
          out_data.right_color   <= box_color[1];
          out_data.center_color  <= box_color[2];
        end
      end
      default: begin
      end
    endcase
  end

endmodule

>>> rtl/region_color_scene_classifier_core.sv
// Pixels transfer one per cycle while in_stall is low. With the back end idle, a frame's
// result follows its last pixel through queue pop, area multiply, the shared serial
// divider over all nine 28-bit totals, box classing and output register load.
// The back end takes one frame at a time; two frames of totals queue, after which
// pixel input stalls. Reset clears sums, queue, sequencer, output valid and the
// previous scene; configuration registers return to their defaults.
`timescale 1ns / 1ps

module region_color_scene_classifier_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [rcsc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [rcsc_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  rcsc_pkg::pixel_t                    in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output rcsc_pkg::result_t                   out_data
);

  rcsc_pkg::cfg_t      cfg;
  logic                q_full;
  logic                q_empty;
  logic                push;
  logic                pop;
  rcsc_pkg::sum_bank_t push_data;
  rcsc_pkg::sum_bank_t q_head;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.left_box_x   <= rcsc_pkg::RST_LEFT_BOX_X;
      cfg.right_box_x  <= rcsc_pkg::RST_RIGHT_BOX_X;
      cfg.center_box_x <= rcsc_pkg::RST_CENTER_BOX_X;
      cfg.upper_box_y  <= rcsc_pkg::RST_UPPER_BOX_Y;
      cfg.center_box_y <= rcsc_pkg::RST_CENTER_BOX_Y;
      cfg.box_span_x   <= rcsc_pkg::RST_BOX_SPAN_X;
      cfg.box_span_y   <= rcsc_pkg::RST_BOX_SPAN_Y;
      cfg.noise_level  <= rcsc_pkg::RST_NOISE_LEVEL;
    end else if (cfg_write) begin
      case (cfg_index)
        rcsc_pkg::REG_LEFT_BOX_X:   cfg.left_box_x   <= cfg_data;
        rcsc_pkg::REG_RIGHT_BOX_X:  cfg.right_box_x  <= cfg_data;
        rcsc_pkg::REG_CENTER_BOX_X: cfg.center_box_x <= cfg_data;
        rcsc_pkg::REG_UPPER_BOX_Y:  cfg.upper_box_y  <= cfg_data;
        rcsc_pkg::REG_CENTER_BOX_Y: cfg.center_box_y <= cfg_data;
        rcsc_pkg::REG_BOX_SPAN_X:   cfg.box_span_x   <= cfg_data;
        rcsc_pkg::REG_BOX_SPAN_Y:   cfg.box_span_y   <= cfg_data;
        rcsc_pkg::REG_NOISE_LEVEL:  cfg.noise_level  <= cfg_data[rcsc_pkg::NOISE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  rcsc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .q_full    (q_full),
    .push      (push),
    .push_data (push_data)
  );

  rcsc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .empty     (q_empty),
    .head      (q_head)
  );

  rcsc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
